// File: src/sequence_replay_filter_defines.svh
// Assertion macros for the sequence replay filter.
// Depends on: a clk_i clock and an rst_ni active-low reset in the using module.
`ifndef SEQUENCE_REPLAY_FILTER_DEFINES_SVH
`define SEQUENCE_REPLAY_FILTER_DEFINES_SVH

// Checked only while out of reset.
`define SRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SRF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: src/srf_pkg.sv
// Shared types and constants of the sequence replay filter.
// No dependencies.
package srf_pkg;

  localparam int unsigned SEQ_W     = 16;
  localparam int unsigned GAP_W     = 15;
  localparam int unsigned VERDICT_W = 3;

  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(1024);

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_FIRST    = 3'd0,
    VERDICT_ADVANCED = 3'd1,
    VERDICT_RESYNC   = 3'd2,
    VERDICT_REPLAY   = 3'd3,
    VERDICT_FULL     = 3'd4
  } verdict_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_DECIDE = 2'b10
  } state_e;

  // What one cell reports to the top level during the decide cycle.
  typedef struct packed {
    logic     match;
    logic     sel;
    logic     fresh;
    verdict_e verdict;
  } cell_res_t;

endpackage

// File: src/srf_cell.sv
// One table entry of the replay filter: address, primed bit and high-water mark.
// Depends on: srf_pkg.
module srf_cell #(
  parameter int unsigned ADDR_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        look_i,
  input  logic                        commit_i,
  input  logic [ADDR_BITS-1:0]        look_addr_i,
  input  logic [ADDR_BITS-1:0]        req_addr_i,
  input  logic [srf_pkg::SEQ_W-1:0]   req_seq_i,
  input  logic [srf_pkg::GAP_W-1:0]   restart_gap_i,
  input  logic                        prev_used_i,
  input  logic                        hit_any_i,
  output logic                        used_o,
  output srf_pkg::cell_res_t          res_o
);

  logic                      used_q, primed_q, match_q, claim_q;
  logic [ADDR_BITS-1:0]      addr_q;
  logic [srf_pkg::SEQ_W-1:0] high_q;
  logic                      sel;
  logic [srf_pkg::SEQ_W-1:0] diff;
  logic                      adv, resync, first;
  logic [srf_pkg::SEQ_W:0]   diff_ext, neg_gap;
  srf_pkg::verdict_e         verdict;
  logic                      fresh;

  // Claim only when no other cell already holds this source.
  assign sel      = match_q | (claim_q & ~hit_any_i);
  assign first    = ~used_q | ~primed_q;
  assign diff     = req_seq_i - high_q;
  assign diff_ext = {diff[srf_pkg::SEQ_W-1], diff};
  assign neg_gap  = (srf_pkg::SEQ_W+1)'(0) - {2'b00, restart_gap_i};
  assign adv      = ~diff[srf_pkg::SEQ_W-1] & (diff != '0);
  assign resync   = $signed(diff_ext) < $signed(neg_gap);

  always_comb begin
    if (first) begin
      verdict = srf_pkg::VERDICT_FIRST;
      fresh   = 1'b1;
    end else if (adv) begin
      verdict = srf_pkg::VERDICT_ADVANCED;
      fresh   = 1'b1;
    end else if (resync) begin
      verdict = srf_pkg::VERDICT_RESYNC;
      fresh   = 1'b1;
    end else begin
      verdict = srf_pkg::VERDICT_REPLAY;
      fresh   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= 1'b0;
      primed_q <= 1'b0;
      match_q  <= 1'b0;
      claim_q  <= 1'b0;
    end else begin
      if (look_i) begin
        match_q <= used_q & (addr_q == look_addr_i);
        claim_q <= ~used_q & prev_used_i;
      end
      if (commit_i && sel) begin
        used_q   <= 1'b1;
        primed_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i && sel) begin
      addr_q <= req_addr_i;
      if (fresh) begin
        high_q <= req_seq_i;
      end
    end
  end

  assign used_o = used_q;

  always_comb begin
    res_o         = '0;
    res_o.match   = match_q;
    res_o.sel     = sel;
    if (sel) begin
      res_o.fresh   = fresh;
      res_o.verdict = verdict;
    end else begin
      res_o.verdict = srf_pkg::VERDICT_FIRST;
    end
  end

endmodule

// File: src/sequence_replay_filter.sv
// Top level of the per-source sequence replay filter.
// Depends on: srf_pkg, srf_cell, sequence_replay_filter_defines.svh.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------
//  in       | in_valid_i / in_ready_o | source_addr_i, seq_num_i
//  out      | out_valid_o/out_ready_i | fresh_o, verdict_o
//  config   | cfg_we_i (no wait)      | cfg_wdata_i (restart gap)
//
// Per item, the accept edge registers the address match and the free-slot claim
// in every cell; the commit in S_DECIDE then updates the selected cell and loads
// the output register.
// Reset empties the table and sets the restart gap to 1024; no clearing pass.
// The decide cycle holds while the output register still waits on out_ready_i.
`include "sequence_replay_filter_defines.svh"

module sequence_replay_filter #(
  parameter int unsigned MAX_SOURCES = 8,
  parameter int unsigned ADDR_BITS   = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ADDR_BITS-1:0]            source_addr_i,
  input  logic [srf_pkg::SEQ_W-1:0]       seq_num_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            fresh_o,
  output logic [srf_pkg::VERDICT_W-1:0]   verdict_o,
  input  logic                            cfg_we_i,
  input  logic [srf_pkg::GAP_W-1:0]       cfg_wdata_i
);

  srf_pkg::state_e                 state_q, state_d;
  logic [srf_pkg::GAP_W-1:0]       gap_q;
  logic [ADDR_BITS-1:0]            req_addr_q;
  logic [srf_pkg::SEQ_W-1:0]       req_seq_q;
  logic                            out_valid_q;
  logic                            fresh_q;
  logic [srf_pkg::VERDICT_W-1:0]   verdict_q;

  logic                            in_fire, commit;
  logic [MAX_SOURCES-1:0]          used_vec, match_vec, sel_vec, used_inc;
  srf_pkg::cell_res_t              res [MAX_SOURCES];
  logic                            hit_any, sel_any, or_fresh;
  logic [srf_pkg::VERDICT_W-1:0]   or_verdict;

  assign in_ready_o = (state_q == srf_pkg::S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  // Commit once the output register is free or is being emptied this cycle.
  assign commit     = (state_q == srf_pkg::S_DECIDE) & (~out_valid_q | out_ready_i);

  // Row of entry cells; entries fill from cell 0 upward, so the first free
  // cell is the one whose left neighbor is used and which is not.
  for (genvar g = 0; g < MAX_SOURCES; g++) begin : g_cell
    logic prev_used;
    if (g == 0) begin : g_head
      assign prev_used = 1'b1;
    end else begin : g_link
      assign prev_used = used_vec[g-1];
    end

    srf_cell #(
      .ADDR_BITS(ADDR_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .look_i       (in_fire),
      .commit_i     (commit),
      .look_addr_i  (source_addr_i),
      .req_addr_i   (req_addr_q),
      .req_seq_i    (req_seq_q),
      .restart_gap_i(gap_q),
      .prev_used_i  (prev_used),
      .hit_any_i    (hit_any),
      .used_o       (used_vec[g]),
      .res_o        (res[g])
    );

    assign match_vec[g] = res[g].match;
    assign sel_vec[g]   = res[g].sel;
  end

  // Merge the cell reports: at most one cell is selected, the rest report zero.
  always_comb begin
    or_fresh   = 1'b0;
    or_verdict = '0;
    for (int i = 0; i < MAX_SOURCES; i++) begin
      or_fresh   = or_fresh | res[i].fresh;
      or_verdict = or_verdict | res[i].verdict;
    end
  end

  assign hit_any  = |match_vec;
  assign sel_any  = |sel_vec;
  assign used_inc = used_vec + MAX_SOURCES'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srf_pkg::S_IDLE: begin
        if (in_fire) begin
          state_d = srf_pkg::S_DECIDE;
        end
      end
      srf_pkg::S_DECIDE: begin
        if (commit) begin
          state_d = srf_pkg::S_IDLE;
        end
      end
      default: state_d = srf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srf_pkg::S_IDLE;
      gap_q       <= srf_pkg::GAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        gap_q <= cfg_wdata_i;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the transaction payload; a full table accepts without any change.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_addr_q <= source_addr_i;
      req_seq_q  <= seq_num_i;
    end
    if (commit) begin
      fresh_q   <= sel_any ? or_fresh : 1'b1;
      verdict_q <= sel_any ? or_verdict : srf_pkg::VERDICT_FULL;
    end
  end

  assign out_valid_o = out_valid_q;
  assign fresh_o     = fresh_q;
  assign verdict_o   = verdict_q;

  `SRF_ASSERT(a_sel_onehot, $onehot0(sel_vec), "more than one entry selected")
  `SRF_ASSERT(a_match_onehot, $onehot0(match_vec), "source held in two entries")
  `SRF_ASSERT(a_used_prefix, (used_vec & used_inc) == '0, "used entries not contiguous")
  `SRF_ASSERT(a_full_only_when_full, out_valid_q && (verdict_q == srf_pkg::VERDICT_FULL) |-> (&used_vec), "table full verdict with a free entry")
  `SRF_ASSERT(a_result_after_decide, $rose(out_valid_q) |-> $past(state_q == srf_pkg::S_DECIDE), "result without a decide cycle")
  `SRF_ASSERT_ALWAYS(a_reject_is_replay, out_valid_q && !fresh_q |-> verdict_q == srf_pkg::VERDICT_REPLAY, "rejected frame without replay verdict")

endmodule

// File: bench/sequence_replay_filter_checker.sv
// Checker for the sequence replay filter: watches the frame, verdict and config ports.
// It predicts each verdict from its own table and compares results in order.
// Depends on: srf_pkg.
module sequence_replay_filter_checker
  import srf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 8,
  parameter int unsigned ADDR_W      = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [ADDR_W-1:0]    source_addr_i,
  input  logic [SEQ_W-1:0]     seq_num_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 fresh_i,
  input  logic [VERDICT_W-1:0] verdict_i,
  input  logic                 cfg_we_i,
  input  logic [GAP_W-1:0]     cfg_wdata_i,
  output int unsigned          pending_o,
  output int unsigned          fail_count_o
);

  typedef struct packed {
    logic [ADDR_W-1:0] source;
    logic [SEQ_W-1:0]  seq;
    logic              fresh;
    verdict_e          verdict;
  } frame_verdict_t;

  logic [GAP_W-1:0]  gap_q;
  logic              used_q   [TABLE_DEPTH];
  logic [ADDR_W-1:0] owner_q  [TABLE_DEPTH];
  logic              primed_q [TABLE_DEPTH];
  logic [SEQ_W-1:0]  mark_q   [TABLE_DEPTH];

  frame_verdict_t verdicts_due [$];
  int unsigned    fails;

  // Judge one frame against the table and update the table as the block would.
  function automatic frame_verdict_t judge_frame(logic [ADDR_W-1:0] src,
                                                 logic [SEQ_W-1:0] seq);
    frame_verdict_t   r;
    int               slot;
    int               i;
    int               d;
    logic [SEQ_W-1:0] diff;
    r.source = src;
    r.seq    = seq;
    slot     = -1;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (slot < 0 && used_q[i] && owner_q[i] == src) slot = i;
    end
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (slot < 0 && !used_q[i]) begin
        slot        = i;
        used_q[i]   = 1'b1;
        owner_q[i]  = src;
        mark_q[i]   = '0;
      end
    end
    if (slot < 0) begin
      r.fresh   = 1'b1;
      r.verdict = VERDICT_FULL;
    end else if (!primed_q[slot]) begin
      primed_q[slot] = 1'b1;
      mark_q[slot]   = seq;
      r.fresh        = 1'b1;
      r.verdict      = VERDICT_FIRST;
    end else begin
      diff = seq - mark_q[slot];
      d    = $signed(diff);
      if (d > 0) begin
        mark_q[slot] = seq;
        r.fresh      = 1'b1;
        r.verdict    = VERDICT_ADVANCED;
      end else if (d < -int'(gap_q)) begin
        mark_q[slot] = seq;
        r.fresh      = 1'b1;
        r.verdict    = VERDICT_RESYNC;
      end else begin
        r.fresh   = 1'b0;
        r.verdict = VERDICT_REPLAY;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_verdict_t want;
    if (!rst_ni) begin
      gap_q = GAP_RESET;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        used_q[i]   = 1'b0;
        owner_q[i]  = '0;
        primed_q[i] = 1'b0;
        mark_q[i]   = '0;
      end
      verdicts_due.delete();
      fails = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) gap_q = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (verdicts_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("[%0t] unexpected result: fresh=%0d verdict=%0d", $time,
                     fresh_i, verdict_i);
        end else begin
          want = verdicts_due.pop_front();
          if (fresh_i !== want.fresh || verdict_i !== want.verdict) begin
            fails++;
            if (fails <= 10)
              $display("[%0t] mismatch src=%02h seq=%04h: fresh exp %0d got %0d, verdict exp %0d got %0d",
                       $time, want.source, want.seq, want.fresh, fresh_i,
                       want.verdict, verdict_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) verdicts_due.push_back(judge_frame(source_addr_i, seq_num_i));
      pending_o    <= verdicts_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

// File: bench/sequence_replay_filter_test.sv
// Top of the sequence replay filter bench: clock, reset, frame and config stimulus, verdict.
// Depends on: srf_pkg, sequence_replay_filter, sequence_replay_filter_checker.
module sequence_replay_filter_test;

  import srf_pkg::*;

  localparam int unsigned ADDR_W      = 8;
  localparam int unsigned TABLE_DEPTH = 8;
  // Cycles without any transaction before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam int unsigned NUM_PHASES  = 6;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [ADDR_W-1:0]    source_addr_i;
  logic [SEQ_W-1:0]     seq_num_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 fresh_o;
  logic [VERDICT_W-1:0] verdict_o;
  logic                 cfg_we_i;
  logic [GAP_W-1:0]     cfg_wdata_i;

  int unsigned pending;
  int unsigned fail_count;

  // Steady phase: neither side idles while this is set.
  logic        calm;
  int unsigned frames_sent;
  int unsigned gap_writes;
  int unsigned stall_cycles;
  int          cur_gap;

  // Addresses that claim the eight table entries; together they drive every address bit
  // both ways.
  logic [ADDR_W-1:0] sources [TABLE_DEPTH];
  // Rough high-water mark per address, kept only to aim sequence numbers near the edges.
  logic [SEQ_W-1:0]  mark_of [256];

  sequence_replay_filter #(
    .MAX_SOURCES (TABLE_DEPTH),
    .ADDR_BITS   (ADDR_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .source_addr_i (source_addr_i),
    .seq_num_i     (seq_num_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .fresh_o       (fresh_o),
    .verdict_o     (verdict_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  sequence_replay_filter_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .source_addr_i (source_addr_i),
    .seq_num_i     (seq_num_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .fresh_i       (fresh_o),
    .verdict_i     (verdict_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  // 12-unit clock period.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Result side: stall about a third of the cycles, never in the steady phase.
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 34);
  end

  // Watchdog: count cycles with no transaction on any port.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i || !rst_ni) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
               stall_cycles, pending);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one frame and hold it until the block takes it. Idle cycles come first, so a
  // frame that follows at once keeps valid high without a drop.
  task automatic send_frame(input logic [ADDR_W-1:0] src, input logic [SEQ_W-1:0] seq);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    source_addr_i <= src;
    seq_num_i     <= seq;
    do @(posedge clk_i); while (!in_ready_o);
    frames_sent++;
  endtask

  // Drop valid and wait until every result has come back. The first edge lets the
  // checker count the transaction that was just accepted.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // Change the restart gap only while the block is idle.
  task automatic write_restart_gap(input logic [GAP_W-1:0] gap);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= gap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_gap  = gap;
    gap_writes++;
  endtask

  // Pick a frame aimed at one of the decision boundaries under the current gap.
  task automatic send_random_frame();
    logic [ADDR_W-1:0] src;
    logic [SEQ_W-1:0]  seq;
    int                step;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      // Stranger: mostly hits the full table.
      send_frame(ADDR_W'($urandom_range(255)), SEQ_W'($urandom_range(65535)));
    end else begin
      src  = sources[$urandom_range(TABLE_DEPTH - 1)];
      pick = $urandom_range(99);
      if (pick < 40)      step = $urandom_range(300, 1);
      else if (pick < 50) step = $urandom_range(32767, 301);
      else if (pick < 60) step = 0;
      else if (pick < 74) step = -int'($urandom_range(cur_gap, 1));
      else if (pick < 84) step = -cur_gap - int'($urandom_range(1));
      else if (pick < 94) step = -int'($urandom_range(32768, cur_gap + 1));
      else                step = $signed(SEQ_W'($urandom_range(65535)));
      seq = SEQ_W'(int'(mark_of[src]) + step);
      // Follow the mark only where the frame should have been taken.
      if (step > 0 || step < -cur_gap) mark_of[src] = seq;
      send_frame(src, seq);
    end
  endtask

  initial begin
    logic [GAP_W-1:0] gap_plan [NUM_PHASES];
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    source_addr_i = '0;
    seq_num_i     = '0;
    out_ready_i   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    calm          = 1'b0;
    frames_sent   = 0;
    gap_writes    = 0;
    stall_cycles  = 0;
    cur_gap       = 1024;
    sources = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h33, 8'hCC};
    for (int i = 0; i < 256; i++) mark_of[i] = '0;
    // Extremes, the out-of-range zero gap, the reset value 1024 and two random settings.
    gap_plan = '{GAP_W'(1), GAP_W'(32767), GAP_W'(0), GAP_W'($urandom_range(32766, 2)),
                 GAP_W'(1024), GAP_W'($urandom_range(32766, 2))};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset gap of 1024.
    send_frame(8'h00, 16'h0000);  // first from source
    send_frame(8'h00, 16'h0000);  // equal sequence number: replay
    send_frame(8'h00, 16'h0001);  // advance by one
    send_frame(8'h00, 16'h8000);  // largest forward step
    send_frame(8'h00, 16'h0000);  // half-range back: resync
    send_frame(8'hFF, 16'hFFFF);  // first, top sequence number
    send_frame(8'hFF, 16'h0000);  // advance across the wrap
    send_frame(8'hFF, 16'hFC00);  // back by exactly the gap: replay
    send_frame(8'hFF, 16'hFBFF);  // back by one more than the gap: resync
    send_frame(8'h55, 16'h1234);
    send_frame(8'h55, 16'h1233);  // back by one: replay
    send_frame(8'hAA, 16'h0000);
    send_frame(8'h0F, 16'h7FFF);
    send_frame(8'hF0, 16'h8000);
    send_frame(8'h33, 16'hABCD);
    send_frame(8'hCC, 16'h5555);  // last free entry
    send_frame(8'h01, 16'h0000);  // table full
    send_frame(8'hFE, 16'hFFFF);  // table full
    send_frame(8'hAA, 16'h0000);  // primed at zero, same again: replay
    send_frame(8'hCC, 16'h5554);

    // Random phases, each under its own gap; the fourth runs with no idling at all.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_restart_gap(gap_plan[phase]);
      calm = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_frame();
    end
    calm = 1'b0;

    drain_results();
    $display("Sent %0d frames under %0d restart-gap settings (reset 1024, 1, 32767, 0, random),",
             frames_sent, gap_writes + 1);
    $display("with random stalls on both sides and one phase run without any.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sequence_replay_filter.f
+incdir+src
src/srf_pkg.sv
src/srf_cell.sv
src/sequence_replay_filter.sv
bench/sequence_replay_filter_checker.sv
bench/sequence_replay_filter_test.sv
